>>> hw/rtl/rdq_pkg.sv
// Shared types and constants for the rotating deque.
// Used by rdq_cell, rotating_deque_with_cursor and rdq_checker; no dependencies.
package rdq_pkg;

	localparam int CAPACITY_DEF   = 16;
	localparam int DATA_WIDTH_DEF = 32;

	// stream payload widths (fixed field widths)
	localparam int OP_W     = 3;
	localparam int VALUE_W  = 32;
	localparam int COUNT_W  = 5;
	localparam int STATUS_W = 2;
	localparam int S_DATA_W = 40;
	localparam int M_DATA_W = 72;

	// operation codes
	localparam logic [OP_W-1:0] OP_QUERY        = 3'd0;
	localparam logic [OP_W-1:0] OP_ADD_FRONT    = 3'd1;
	localparam logic [OP_W-1:0] OP_ADD_BACK     = 3'd2;
	localparam logic [OP_W-1:0] OP_ADVANCE      = 3'd3;
	localparam logic [OP_W-1:0] OP_REMOVE_FRONT = 3'd4;
	localparam logic [OP_W-1:0] OP_REMOVE_BACK  = 3'd5;

	// status codes
	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY_ERR = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL_ERR  = 2'd2;

	// command broadcast to every cell of the chain
	typedef enum logic [2:0] {
		CMD_HOLD       = 3'd0,
		CMD_PUSH_FRONT = 3'd1,
		CMD_PUSH_BACK  = 3'd2,
		CMD_ROTATE     = 3'd3,
		CMD_POP_FRONT  = 3'd4
	} cell_cmd_t;

	typedef struct packed {
		cell_cmd_t cmd;
		logic      is_back; // cell holds the back element
		logic      is_tail; // first free cell after the back element
	} cell_ctrl_t;

	typedef enum logic [2:0] {
		FSM_IDLE = 3'b001,
		FSM_EXEC = 3'b010,
		FSM_FORM = 3'b100
	} fsm_state_t;

endpackage

>>> hw/rtl/rdq_cell.sv
// One storage cell of the deque chain: holds a word, trades it with its neighbors.
// Depends on rdq_pkg for the cell command and control struct.
module rdq_cell #(
	parameter int DATA_WIDTH = rdq_pkg::DATA_WIDTH_DEF
) (
	input  logic                  clk,
	input  rdq_pkg::cell_ctrl_t   ctrl,
	input  logic [DATA_WIDTH-1:0] left_word,
	input  logic [DATA_WIDTH-1:0] right_word,
	input  logic [DATA_WIDTH-1:0] front_word,
	input  logic [DATA_WIDTH-1:0] value_word,
	output logic [DATA_WIDTH-1:0] word,
	output logic [DATA_WIDTH-1:0] back_word
);

	logic [DATA_WIDTH-1:0] word_q;

	always_ff @(posedge clk) begin
		unique case (ctrl.cmd)
			rdq_pkg::CMD_PUSH_FRONT: word_q <= left_word;
			rdq_pkg::CMD_PUSH_BACK: begin
				if (ctrl.is_tail) begin
					word_q <= value_word;
				end
			end
			rdq_pkg::CMD_ROTATE: begin
				// back cell takes the old front, the rest move one place forward
				if (ctrl.is_back) begin
					word_q <= front_word;
				end else begin
					word_q <= right_word;
				end
			end
			rdq_pkg::CMD_POP_FRONT: word_q <= right_word;
			default: word_q <= word_q;
		endcase
	end

	assign word      = word_q;
	assign back_word = word_q & {DATA_WIDTH{ctrl.is_back}};

endmodule

>>> hw/rtl/rotating_deque_with_cursor.sv
// Top level of the rotating deque: control sequencer, count and a chain of rdq_cell.
// Depends on rdq_pkg and rdq_cell.
//
// Usage:
//   Requests enter on the s_ group: s_tdata holds operation and value. Each request
//   produces exactly one result on the m_ group: m_tdata holds front_value,
//   back_value, is_empty, element_count and status.
//   The list is a row of CAPACITY cells; cell 0 always holds the front element and
//   cell count-1 the back. Add-front, remove-front and advance shift words between
//   neighboring cells; advance also moves the front word into the back cell.
//   After a request is accepted the cells and count are updated, then front and
//   back are gathered into the output register as soon as it is free.
//   A new request is accepted while idle, or in the same cycle the previous result
//   is loaded into the output register.
//   A finished result waits in the output register while the next request is
//   accepted and executed; if the receiver stalls, the block holds that next result
//   internally and accepts nothing further until the output register frees up.
//   Reset clears the list to empty and the output to idle; cell contents are left
//   as they are and are never read before being written.
module rotating_deque_with_cursor #(
	parameter int CAPACITY   = rdq_pkg::CAPACITY_DEF,
	parameter int DATA_WIDTH = rdq_pkg::DATA_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// [2:0] operation, [34:3] value, [39:35] zero
	input  logic [rdq_pkg::S_DATA_W-1:0]  s_tdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// [31:0] front_value, [63:32] back_value, [64] is_empty,
	// [69:65] element_count, [71:70] status
	output logic [rdq_pkg::M_DATA_W-1:0]  m_tdata
);

	localparam int CW = $clog2(CAPACITY + 1);

	rdq_pkg::fsm_state_t state_q;
	logic [rdq_pkg::OP_W-1:0]     op_q;
	logic [DATA_WIDTH-1:0]        value_q;
	logic [CW-1:0]                count_q;
	logic [rdq_pkg::STATUS_W-1:0] status_q;
	logic                         m_tvalid_q;
	logic [rdq_pkg::M_DATA_W-1:0] m_tdata_q;

	logic accept;
	logic out_free;
	logic form_load;
	logic full;
	logic empty;
	rdq_pkg::cell_cmd_t           cmd;
	logic [CW-1:0]                count_next;
	logic [rdq_pkg::STATUS_W-1:0] status_next;

	logic [63:0]           value_ext;
	logic [DATA_WIDTH-1:0] cell_word [CAPACITY];
	logic [DATA_WIDTH-1:0] cell_back [CAPACITY];
	logic [DATA_WIDTH-1:0] back_word;
	logic [63:0]           front_ext;
	logic [63:0]           back_ext;
	logic [15:0]           count_ext;

	assign out_free  = !m_tvalid_q || m_tready;
	assign form_load = (state_q == rdq_pkg::FSM_FORM) && out_free;
	assign s_tready  = (state_q == rdq_pkg::FSM_IDLE) || form_load;
	assign accept    = s_tvalid && s_tready;

	assign full  = (count_q == CW'(CAPACITY));
	assign empty = (count_q == '0);

	assign value_ext = {32'd0, s_tdata[34:3]};

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rdq_pkg::FSM_IDLE;
		end else begin
			unique case (state_q)
				rdq_pkg::FSM_IDLE: begin
					if (accept) begin
						state_q <= rdq_pkg::FSM_EXEC;
					end
				end
				rdq_pkg::FSM_EXEC: state_q <= rdq_pkg::FSM_FORM;
				rdq_pkg::FSM_FORM: begin
					if (accept) begin
						state_q <= rdq_pkg::FSM_EXEC;
					end else if (form_load) begin
						state_q <= rdq_pkg::FSM_IDLE;
					end
				end
				default: state_q <= rdq_pkg::FSM_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= s_tdata[2:0];
			value_q <= value_ext[DATA_WIDTH-1:0];
		end
	end

	// decode the request against the current count
	always_comb begin
		cmd         = rdq_pkg::CMD_HOLD;
		count_next  = count_q;
		status_next = rdq_pkg::ST_OK;
		unique case (op_q)
			rdq_pkg::OP_ADD_FRONT, rdq_pkg::OP_ADD_BACK: begin
				if (full) begin
					status_next = rdq_pkg::ST_FULL_ERR;
				end else begin
					cmd        = (op_q == rdq_pkg::OP_ADD_FRONT) ? rdq_pkg::CMD_PUSH_FRONT
					                                             : rdq_pkg::CMD_PUSH_BACK;
					count_next = count_q + CW'(1);
				end
			end
			rdq_pkg::OP_ADVANCE: begin
				if (empty) begin
					status_next = rdq_pkg::ST_EMPTY_ERR;
				end else begin
					cmd = rdq_pkg::CMD_ROTATE;
				end
			end
			rdq_pkg::OP_REMOVE_FRONT, rdq_pkg::OP_REMOVE_BACK: begin
				if (empty) begin
					status_next = rdq_pkg::ST_EMPTY_ERR;
				end else begin
					cmd        = (op_q == rdq_pkg::OP_REMOVE_FRONT) ? rdq_pkg::CMD_POP_FRONT
					                                                : rdq_pkg::CMD_HOLD;
					count_next = count_q - CW'(1);
				end
			end
			default: begin
				cmd = rdq_pkg::CMD_HOLD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			status_q <= rdq_pkg::ST_OK;
		end else if (state_q == rdq_pkg::FSM_EXEC) begin
			count_q  <= count_next;
			status_q <= status_next;
		end
	end

	// cell chain: cell 0 is the front
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		rdq_pkg::cell_ctrl_t   ctrl;
		logic [DATA_WIDTH-1:0] left_word;
		logic [DATA_WIDTH-1:0] right_word;

		assign ctrl.cmd     = (state_q == rdq_pkg::FSM_EXEC) ? cmd : rdq_pkg::CMD_HOLD;
		assign ctrl.is_back = (count_q == CW'(i + 1));
		assign ctrl.is_tail = (count_q == CW'(i));

		if (i == 0) begin : g_first
			assign left_word = value_q;
		end else begin : g_inner
			assign left_word = cell_word[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign right_word = '0;
		end else begin : g_mid
			assign right_word = cell_word[i+1];
		end

		rdq_cell #(
			.DATA_WIDTH (DATA_WIDTH)
		) u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.left_word  (left_word),
			.right_word (right_word),
			.front_word (cell_word[0]),
			.value_word (value_q),
			.word       (cell_word[i]),
			.back_word  (cell_back[i])
		);
	end

	// only the back cell drives a nonzero word
	always_comb begin
		back_word = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			back_word = back_word | cell_back[i];
		end
	end

	assign front_ext = empty ? 64'd0 : 64'(cell_word[0]);
	assign back_ext  = 64'(back_word);
	assign count_ext = 16'(count_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (form_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (form_load) begin
			m_tdata_q <= {status_q, count_ext[4:0], empty, back_ext[31:0], front_ext[31:0]};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

>>> hw/rtl/rdq_checker.sv
// Port-level checks for rotating_deque_with_cursor, attached by bind.
// Depends on rdq_pkg for the stream widths and status codes.
module rdq_port_props (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         s_tvalid,
	input logic                         s_tready,
	input logic                         m_tvalid,
	input logic                         m_tready,
	input logic [rdq_pkg::M_DATA_W-1:0] m_tdata
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// no request is accepted in the cycle after an accepted one
	a_req_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request accepted on consecutive cycles");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[64] == (m_tdata[69:65] == 5'd0)))
		else $error("empty flag disagrees with count");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[64] |-> (m_tdata[63:0] == 64'd0))
		else $error("empty list reports nonzero front or back");

	a_empty_err: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[71:70] == rdq_pkg::ST_EMPTY_ERR) |-> m_tdata[64])
		else $error("empty error on a list that is not empty");

endmodule

bind rotating_deque_with_cursor rdq_port_props u_port_props (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

>>> dv/rdq_checker.sv
// Checker for the rotating deque: watches both stream channels, predicts each result
// from the accepted requests and compares it with the returned one.
// Depends on rdq_pkg.
module rdq_checker
	import rdq_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	input  logic                s_tready,
	input  logic [S_DATA_W-1:0] s_tdata,
	input  logic                m_tvalid,
	input  logic                m_tready,
	input  logic [M_DATA_W-1:0] m_tdata,
	output int                  mismatches,
	output int                  outstanding
);

	localparam int PTR_W = $clog2(CAPACITY_DEF);

	// laid out to match m_tdata, highest field first
	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [COUNT_W-1:0]  count;
		logic                empty;
		logic [VALUE_W-1:0]  back;
		logic [VALUE_W-1:0]  front;
	} deque_view_t;

	logic [VALUE_W-1:0] ring [CAPACITY_DEF];
	logic [PTR_W-1:0]   head;
	logic [COUNT_W-1:0] fill;
	deque_view_t        views_due[$];
	deque_view_t        got, want;
	int                 errors;

	task automatic apply_request(input logic [OP_W-1:0] op, input logic [VALUE_W-1:0] word);
		deque_view_t      v;
		logic             full, empty;
		logic [PTR_W-1:0] tail, back_slot;
		full  = fill == CAPACITY_DEF;
		empty = fill == 0;
		tail  = head + fill[PTR_W-1:0];
		v.status = ST_OK;
		case (op)
			OP_ADD_FRONT: begin
				if (full) begin
					v.status = ST_FULL_ERR;
				end else begin
					head = head - 1'b1;
					ring[head] = word;
					fill = fill + 1'b1;
				end
			end
			OP_ADD_BACK: begin
				if (full) begin
					v.status = ST_FULL_ERR;
				end else begin
					ring[tail] = word;
					fill = fill + 1'b1;
				end
			end
			OP_ADVANCE: begin
				if (empty) begin
					v.status = ST_EMPTY_ERR;
				end else begin
					// when full the front slot already is the slot after the back
					if (!full)
						ring[tail] = ring[head];
					head = head + 1'b1;
				end
			end
			OP_REMOVE_FRONT: begin
				if (empty) begin
					v.status = ST_EMPTY_ERR;
				end else begin
					head = head + 1'b1;
					fill = fill - 1'b1;
				end
			end
			OP_REMOVE_BACK: begin
				if (empty)
					v.status = ST_EMPTY_ERR;
				else
					fill = fill - 1'b1;
			end
			default: ; // query and unused codes leave the list alone
		endcase
		back_slot = head + fill[PTR_W-1:0] - 1'b1;
		v.count = fill;
		v.empty = fill == 0;
		v.front = v.empty ? '0 : ring[head];
		v.back  = v.empty ? '0 : ring[back_slot];
		views_due.push_back(v);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head = '0;
			fill = '0;
			views_due.delete();
			errors = 0;
			mismatches  <= 0;
			outstanding <= 0;
		end else begin
			// retire the result first: this edge's request has no result yet
			if (m_tvalid && m_tready) begin
				got = m_tdata;
				if (views_due.size() == 0) begin
					if (errors < 10)
						$display("%0t: result with nothing outstanding: %h", $realtime, m_tdata);
					errors++;
				end else begin
					want = views_due.pop_front();
					if (got.front !== want.front || got.back !== want.back ||
						got.empty !== want.empty || got.count !== want.count ||
						got.status !== want.status) begin
						if (errors < 10) begin
							$write("%0t: mismatch front %h/%h back %h/%h ", $realtime,
								want.front, got.front, want.back, got.back);
							$display("empty %b/%b count %0d/%0d status %0d/%0d (expected/actual)",
								want.empty, got.empty, want.count, got.count,
								want.status, got.status);
						end
						errors++;
					end
				end
			end
			if (s_tvalid && s_tready)
				apply_request(s_tdata[OP_W-1:0], s_tdata[OP_W +: VALUE_W]);
			mismatches  <= errors;
			outstanding <= views_due.size();
		end
	end

endmodule

>>> dv/rotating_deque_with_cursor_tb.sv
// Testbench top for the rotating deque: clock, reset, request stimulus and result
// back-pressure, verdict. Depends on rdq_pkg, rotating_deque_with_cursor and rdq_checker.
module rotating_deque_with_cursor_tb;
	import rdq_pkg::*;

	// codes outside the defined set behave as a query
	localparam logic [OP_W-1:0] OP_SPARE_A = 3'd6;
	localparam logic [OP_W-1:0] OP_SPARE_B = 3'd7;
	localparam int PAD_W = S_DATA_W - OP_W - VALUE_W;

	logic                clk      = 1'b0;
	logic                arst_n   = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata  = '0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [M_DATA_W-1:0] m_tdata;
	int                  mismatches;
	int                  outstanding;

	int rx_cycle = 0;
	int rx_hold  = 0;
	int rx_mode  = 0;

	rotating_deque_with_cursor dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	rdq_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.mismatches (mismatches),
		.outstanding(outstanding)
	);

	always #5 clk = ~clk;

	initial begin
		#2000000;
		$display("tb: failure");
		$finish;
	end

	// receiver: pick a new random stall pattern periodically, with two long hold-offs
	always @(posedge clk) begin
		rx_cycle++;
		if (rx_cycle % 64 == 0)
			rx_mode = $urandom_range(0, 3);
		if (rx_cycle == 600 || rx_cycle == 6000)
			rx_hold = 80;
		if (rx_hold > 0) begin
			rx_hold--;
			m_tready <= 1'b0;
		end else begin
			case (rx_mode)
				0: m_tready <= 1'b1;
				1: m_tready <= 1'($urandom_range(0, 1));
				2: m_tready <= ($urandom_range(0, 3) == 0);
				default: m_tready <= rx_cycle[0];
			endcase
		end
	end

	task automatic offer(input logic [OP_W-1:0] op, input logic [VALUE_W-1:0] word, input int gap);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {{PAD_W{1'b0}}, word, op};
		do @(posedge clk); while (!s_tready);
	endtask

	// hold off new requests until every outstanding result has returned
	task automatic drain_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	initial begin
		logic [OP_W-1:0]    op;
		logic [VALUE_W-1:0] word;
		int                 mode, roll, gap, burst_left, waited, fails;
		burst_left = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty list: errors, query, the spare codes and the first adds
		offer(OP_QUERY, 32'h0, 0);
		offer(OP_ADVANCE, 32'h0, 0);
		offer(OP_REMOVE_FRONT, 32'h0, 0);
		offer(OP_REMOVE_BACK, 32'h0, 0);
		offer(OP_SPARE_A, 32'hFFFFFFFF, 0);
		offer(OP_SPARE_B, 32'h0, 0);
		offer(OP_ADD_FRONT, 32'hFFFFFFFF, 0);
		offer(OP_ADD_BACK, 32'h0, 0);
		// fill to capacity from both ends
		for (int k = 0; k < 14; k++)
			offer(k[0] ? OP_ADD_FRONT : OP_ADD_BACK,
				k[0] ? ~(32'h1 << (2 * k)) : (32'h1 << (2 * k + 1)), 0);
		offer(OP_ADD_FRONT, 32'hA5A5A5A5, 0);
		offer(OP_ADD_BACK, 32'h5A5A5A5A, 0);
		offer(OP_ADVANCE, 32'h0, 0);
		offer(OP_REMOVE_FRONT, 32'h0, 0);
		offer(OP_ADVANCE, 32'h0, 0);
		offer(OP_REMOVE_BACK, 32'h0, 0);
		drain_results();

		mode = 0;
		for (int i = 0; i < 1900; i++) begin
			if (i % 40 == 0)
				mode = $urandom_range(0, 3);
			if (i == 950)
				drain_results();
			roll = $urandom_range(0, 99);
			if (roll < 3) begin
				op = OP_W'($urandom_range(OP_SPARE_A, OP_SPARE_B));
			end else begin
				case (mode)
					0: begin // mostly adds: reach full
						if (roll < 60)
							op = $urandom_range(0, 1) ? OP_ADD_FRONT : OP_ADD_BACK;
						else if (roll < 75)
							op = OP_ADVANCE;
						else if (roll < 85)
							op = OP_QUERY;
						else
							op = $urandom_range(0, 1) ? OP_REMOVE_FRONT : OP_REMOVE_BACK;
					end
					1: begin // mostly removes: reach empty
						if (roll < 60)
							op = $urandom_range(0, 1) ? OP_REMOVE_FRONT : OP_REMOVE_BACK;
						else if (roll < 75)
							op = OP_ADVANCE;
						else if (roll < 85)
							op = OP_QUERY;
						else
							op = $urandom_range(0, 1) ? OP_ADD_FRONT : OP_ADD_BACK;
					end
					2: op = OP_W'($urandom_range(OP_QUERY, OP_REMOVE_BACK));
					default: op = (roll < 50) ? OP_ADVANCE
						: OP_W'($urandom_range(OP_QUERY, OP_REMOVE_BACK));
				endcase
			end
			case ($urandom_range(0, 7))
				0: word = '0;
				1: word = '1;
				2: word = 32'h1 << $urandom_range(0, 31);
				default: word = $urandom;
			endcase
			gap = 0;
			if (burst_left == 0) begin
				gap = $urandom_range(1, 8);
				burst_left = $urandom_range(1, 30);
			end
			burst_left--;
			offer(op, word, gap);
		end

		s_tvalid <= 1'b0;
		@(posedge clk);
		waited = 0;
		while (outstanding != 0 && waited < 5000) begin
			@(posedge clk);
			waited++;
		end
		repeat (8) @(posedge clk);
		fails = mismatches + ((outstanding != 0) ? 1 : 0);
		if (fails == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

>>> filelist.f
hw/rtl/rdq_pkg.sv
hw/rtl/rdq_cell.sv
hw/rtl/rotating_deque_with_cursor.sv
hw/rtl/rdq_checker.sv
dv/rdq_checker.sv
dv/rotating_deque_with_cursor_tb.sv
